// ===== sv/tspl_pkg.sv =====
// Shared types, widths and constants of the triangle pressure load block.
package tspl_pkg;

    localparam int COORD_W    = 32;
    localparam int LOAD_W     = 64;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int MAG_W      = COORD_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int NORM_W     = PROD_W + 2;
    localparam int NMAG_W     = PROD_W + 1;
    localparam int SUM_W      = NMAG_W + COORD_W;
    localparam int DIG_W      = 16;
    localparam int NUM_DIG    = LOAD_W / DIG_W;
    localparam int RULE_W     = 2;
    localparam int DIV_W      = 2;
    localparam int RECIP_W    = DIG_W + DIV_W;
    localparam int RECIP_SH   = DIG_W + 3;
    localparam int NUM_LANES  = 3;
    localparam int LANE_STAGES = 7 + NUM_DIG;

    typedef enum logic [RULE_W-1:0] {
        RULE_3PT  = 2'd0,
        RULE_7PT  = 2'd1,
        RULE_13PT = 2'd2,
        RULE_RSVD = 2'd3
    } rule_t;

    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Every rule integrates a linear shape function to exactly 1/6, i.e. half
    // weight sum over 3; the lanes divide by the odd part with a reciprocal.
    typedef struct packed {
        logic [DIV_W-1:0]   div;
        logic [RECIP_W-1:0] recip;
    } div_const_t;

    typedef struct packed {
        logic              neg;
        logic [LOAD_W-1:0] mag;
    } lane_res_t;

    function automatic div_const_t rule_div(input rule_t rule);
        div_const_t dc;
        unique case (rule)
            RULE_3PT:  dc = '{div: DIV_W'(3), recip: RECIP_W'(174763)};
            RULE_7PT:  dc = '{div: DIV_W'(3), recip: RECIP_W'(174763)};
            RULE_13PT: dc = '{div: DIV_W'(3), recip: RECIP_W'(174763)};
            default:   dc = '{div: DIV_W'(3), recip: RECIP_W'(174763)};
        endcase
        return dc;
    endfunction

endpackage

// ===== sv/tri_surface_pressure_load.sv =====
// Top level of the triangle pressure load block: edges, three lanes, merge.
// Results strobe on done after the edge registers, the lane stages and the merge register.
// Throughput: one word per cycle; busy is always low, the lanes are fully pipelined.
// The longest stages are the 32x32 edge products and the 33x32 pressure products.
// Reset (rst_n, async low) clears rule_reg and the valid pipeline; data is not reset.
// done is a one-cycle strobe; the receiver cannot stall.
module tri_surface_pressure_load
    import tspl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    input  logic                  cfg_wr_en,
    input  logic [RULE_W-1:0]     cfg_wr_data,
    input  logic signed [COORD_W-1:0] node1_x,
    input  logic signed [COORD_W-1:0] node1_y,
    input  logic signed [COORD_W-1:0] node1_z,
    input  logic signed [COORD_W-1:0] node2_x,
    input  logic signed [COORD_W-1:0] node2_y,
    input  logic signed [COORD_W-1:0] node2_z,
    input  logic signed [COORD_W-1:0] node3_x,
    input  logic signed [COORD_W-1:0] node3_y,
    input  logic signed [COORD_W-1:0] node3_z,
    input  logic signed [COORD_W-1:0] pressure,
    output logic signed [LOAD_W-1:0]  load_n1_x,
    output logic signed [LOAD_W-1:0]  load_n1_y,
    output logic signed [LOAD_W-1:0]  load_n1_z,
    output logic signed [LOAD_W-1:0]  load_n2_x,
    output logic signed [LOAD_W-1:0]  load_n2_y,
    output logic signed [LOAD_W-1:0]  load_n2_z,
    output logic signed [LOAD_W-1:0]  load_n3_x,
    output logic signed [LOAD_W-1:0]  load_n3_y,
    output logic signed [LOAD_W-1:0]  load_n3_z
);

    rule_t rule_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rule_reg <= RULE_3PT;
        else if (cfg_wr_en)
            rule_reg <= rule_t'(cfg_wr_data);
    end

    assign busy = 1'b0;

    // edge vectors
    edge_t  e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    coord_t p_reg;
    logic   v1_reg;
    logic [LANE_STAGES-1:0] vpipe_reg;

    always_ff @(posedge clk)
    begin
        e1x_reg <= EDGE_W'(node2_x) - EDGE_W'(node1_x);
        e1y_reg <= EDGE_W'(node2_y) - EDGE_W'(node1_y);
        e1z_reg <= EDGE_W'(node2_z) - EDGE_W'(node1_z);
        e2x_reg <= EDGE_W'(node3_x) - EDGE_W'(node1_x);
        e2y_reg <= EDGE_W'(node3_y) - EDGE_W'(node1_y);
        e2z_reg <= EDGE_W'(node3_z) - EDGE_W'(node1_z);
        p_reg   <= pressure;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            vpipe_reg <= '0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            vpipe_reg <= {vpipe_reg[LANE_STAGES-2:0], v1_reg};
        end
    end

    lane_res_t         res  [NUM_LANES];
    logic [LOAD_W-1:0] load [NUM_LANES];

    // n = e2 x e1
    tspl_lane u_lane_x (
        .clk  (clk),
        .rule (rule_reg),
        .a1   (e2y_reg),
        .a2   (e1z_reg),
        .b1   (e1y_reg),
        .b2   (e2z_reg),
        .p    (p_reg),
        .res  (res[0])
    );

    tspl_lane u_lane_y (
        .clk  (clk),
        .rule (rule_reg),
        .a1   (e2z_reg),
        .a2   (e1x_reg),
        .b1   (e1z_reg),
        .b2   (e2x_reg),
        .p    (p_reg),
        .res  (res[1])
    );

    tspl_lane u_lane_z (
        .clk  (clk),
        .rule (rule_reg),
        .a1   (e2x_reg),
        .a2   (e1y_reg),
        .b1   (e1x_reg),
        .b2   (e2y_reg),
        .p    (p_reg),
        .res  (res[2])
    );

    tspl_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (vpipe_reg[LANE_STAGES-1]),
        .res   (res),
        .done  (done),
        .load  (load)
    );

    // all three nodes carry the same load
    assign load_n1_x = $signed(load[0]);
    assign load_n1_y = $signed(load[1]);
    assign load_n1_z = $signed(load[2]);
    assign load_n2_x = $signed(load[0]);
    assign load_n2_y = $signed(load[1]);
    assign load_n2_z = $signed(load[2]);
    assign load_n3_x = $signed(load[0]);
    assign load_n3_y = $signed(load[1]);
    assign load_n3_z = $signed(load[2]);

endmodule

// ===== sv/tspl_lane.sv =====
// One normal-component lane: cross term, pressure product, rounding, divide by six.
module tspl_lane
    import tspl_pkg::*;
(
    input  logic          clk,
    input  rule_t         rule,
    input  edge_t         a1,
    input  edge_t         a2,
    input  edge_t         b1,
    input  edge_t         b2,
    input  coord_t        p,
    output lane_res_t     res
);

    div_const_t dc;
    assign dc = rule_div(rule);

    // magnitudes and signs
    logic [MAG_W-1:0] ma1_reg, ma2_reg, mb1_reg, mb2_reg, pm2_reg;
    logic             sa2_reg, sb2_reg, sp2_reg;

    always_ff @(posedge clk)
    begin
        ma1_reg <= a1[EDGE_W-1] ? MAG_W'(-a1) : MAG_W'(a1);
        ma2_reg <= a2[EDGE_W-1] ? MAG_W'(-a2) : MAG_W'(a2);
        mb1_reg <= b1[EDGE_W-1] ? MAG_W'(-b1) : MAG_W'(b1);
        mb2_reg <= b2[EDGE_W-1] ? MAG_W'(-b2) : MAG_W'(b2);
        pm2_reg <= p[COORD_W-1] ? MAG_W'(-p) : MAG_W'(p);
        sa2_reg <= a1[EDGE_W-1] ^ a2[EDGE_W-1];
        sb2_reg <= b1[EDGE_W-1] ^ b2[EDGE_W-1];
        sp2_reg <= p[COORD_W-1];
    end

    // edge products
    logic [PROD_W-1:0] pa3_reg, pb3_reg;
    logic [MAG_W-1:0]  pm3_reg;
    logic              sa3_reg, sb3_reg, sp3_reg;

    always_ff @(posedge clk)
    begin
        pa3_reg <= PROD_W'(ma1_reg) * PROD_W'(ma2_reg);
        pb3_reg <= PROD_W'(mb1_reg) * PROD_W'(mb2_reg);
        pm3_reg <= pm2_reg;
        sa3_reg <= sa2_reg;
        sb3_reg <= sb2_reg;
        sp3_reg <= sp2_reg;
    end

    // signed products
    logic signed [NORM_W-1:0] pas4_reg, pbs4_reg;
    logic signed [NORM_W-1:0] pa_ext, pb_ext;
    logic [MAG_W-1:0]         pm4_reg;
    logic                     sp4_reg;

    assign pa_ext = $signed({2'b00, pa3_reg});
    assign pb_ext = $signed({2'b00, pb3_reg});

    always_ff @(posedge clk)
    begin
        pas4_reg <= sa3_reg ? -pa_ext : pa_ext;
        pbs4_reg <= sb3_reg ? -pb_ext : pb_ext;
        pm4_reg  <= pm3_reg;
        sp4_reg  <= sp3_reg;
    end

    // normal component
    logic signed [NORM_W-1:0] n5_reg;
    logic [MAG_W-1:0]         pm5_reg;
    logic                     sp5_reg;

    always_ff @(posedge clk)
    begin
        n5_reg  <= pas4_reg - pbs4_reg;
        pm5_reg <= pm4_reg;
        sp5_reg <= sp4_reg;
    end

    // normal magnitude, final sign
    logic [NMAG_W-1:0] nm6_reg;
    logic [MAG_W-1:0]  pm6_reg;
    logic              sn6_reg;

    always_ff @(posedge clk)
    begin
        nm6_reg <= n5_reg[NORM_W-1] ? NMAG_W'(-n5_reg) : NMAG_W'(n5_reg);
        pm6_reg <= pm5_reg;
        sn6_reg <= n5_reg[NORM_W-1] ^ sp5_reg;
    end

    // partial products with pressure
    localparam int HI_W = NMAG_W - MAG_W;

    logic [PROD_W-1:0]       lo7_reg;
    logic [HI_W+MAG_W-1:0]   hi7_reg;
    logic                    sn7_reg;

    always_ff @(posedge clk)
    begin
        lo7_reg <= PROD_W'(nm6_reg[MAG_W-1:0]) * PROD_W'(pm6_reg);
        hi7_reg <= (HI_W+MAG_W)'(nm6_reg[NMAG_W-1:MAG_W]) * (HI_W+MAG_W)'(pm6_reg);
        sn7_reg <= sn6_reg;
    end

    // sum, add half the divisor, drop the low 33 bits
    logic [SUM_W-1:0]  sum8;
    logic [LOAD_W-1:0] v8_reg;
    logic              sn8_reg;

    assign sum8 = (SUM_W'(hi7_reg) << MAG_W) + SUM_W'(lo7_reg)
                + (SUM_W'(3) << MAG_W);

    always_ff @(posedge clk)
    begin
        v8_reg  <= sum8[SUM_W-1 -: LOAD_W];
        sn8_reg <= sn7_reg;
    end

    // divide by three, one 16-bit digit per stage, top digit first
    logic [LOAD_W-1:0] dw_reg [NUM_DIG];
    logic [DIV_W-1:0]  dr_reg [NUM_DIG];
    logic              dn_reg [NUM_DIG];

    for (genvar d = 0; d < NUM_DIG; d++)
    begin : g_div
        logic [LOAD_W-1:0]           w_in;
        logic [LOAD_W-1:0]           w_out;
        logic [DIV_W-1:0]            r_in;
        logic                        n_in;
        logic [RECIP_W-1:0]          t;
        logic [2*RECIP_W-1:0]        prod;
        logic [DIG_W-1:0]            q;
        logic [RECIP_W-1:0]          qd;

        if (d == 0)
        begin : g_first
            assign w_in = v8_reg;
            assign r_in = '0;
            assign n_in = sn8_reg;
        end
        else
        begin : g_next
            assign w_in = dw_reg[d-1];
            assign r_in = dr_reg[d-1];
            assign n_in = dn_reg[d-1];
        end

        assign t    = {r_in, w_in[LOAD_W-1-DIG_W*d -: DIG_W]};
        assign prod = (2*RECIP_W)'(t) * (2*RECIP_W)'(dc.recip);
        assign q    = prod[RECIP_SH +: DIG_W];
        assign qd   = RECIP_W'(q) * RECIP_W'(dc.div);

        always_comb
        begin
            w_out = w_in;
            w_out[LOAD_W-1-DIG_W*d -: DIG_W] = q;
        end

        always_ff @(posedge clk)
        begin
            dw_reg[d] <= w_out;
            dr_reg[d] <= DIV_W'(t - qd);
            dn_reg[d] <= n_in;
        end
    end

    assign res.mag = dw_reg[NUM_DIG-1];
    assign res.neg = dn_reg[NUM_DIG-1];

endmodule

// ===== sv/tspl_merge.sv =====
// Merge stage: applies sign and clamp to the lane results and registers the output word.
module tspl_merge
    import tspl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  lane_res_t          res [NUM_LANES],
    output logic               done,
    output logic [LOAD_W-1:0]  load [NUM_LANES]
);

    localparam logic [LOAD_W-1:0] POS_MAX = {1'b0, {(LOAD_W-1){1'b1}}};
    localparam logic [LOAD_W-1:0] NEG_MIN = {1'b1, {(LOAD_W-1){1'b0}}};

    logic              done_reg;
    logic [LOAD_W-1:0] load_reg  [NUM_LANES];
    logic [LOAD_W-1:0] load_next [NUM_LANES];

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (res[i].mag[LOAD_W-1])
                load_next[i] = res[i].neg ? NEG_MIN : POS_MAX;
            else
                load_next[i] = res[i].neg ? -res[i].mag : res[i].mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
            load_reg[i] <= load_next[i];
    end

    assign done = done_reg;
    assign load = load_reg;

endmodule
